FILE: rtl/dtmf_gd_pkg.sv
package dtmf_gd_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int DIGIT_W         = 4;
    localparam int TONE_W          = 3;
    localparam int COEF_W          = 18;
    localparam int Q_W             = 48;
    localparam int HALF_W          = 24;
    localparam int CNT_W           = 13;
    localparam int NUM_TONES       = 8;
    localparam int TIDX_W          = 3;
    localparam int TONES_PER_GROUP = 4;
    localparam int GIDX_W          = 2;
    localparam int MUL_W           = 128;
    localparam int MULB_W          = 48;
    localparam int X_W             = 2 * Q_W;
    localparam int P_W             = 112;
    localparam int APB_DW          = 32;
    localparam int APB_AW          = TIDX_W + 2;

    localparam int MAX_BLOCK_DEF   = 1024;
    localparam int COEF_FRAC_DEF   = 16;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 4'd10;
    localparam logic [TONE_W-1:0]  REJECTED = 3'd4;

    localparam logic [DIGIT_W-1:0] DIGIT_MAP [16] = '{
        4'd1,  4'd2, 4'd3,  4'd10,
        4'd4,  4'd5, 4'd6,  4'd10,
        4'd7,  4'd8, 4'd9,  4'd10,
        4'd10, 4'd0, 4'd10, 4'd10
    };

    typedef enum logic [1:0] {
        MOP_SQ1 = 2'd0,
        MOP_SQ2 = 2'd1,
        MOP_X12 = 2'd2,
        MOP_XC  = 2'd3
    } t_mop;

    typedef struct packed {
        logic [TIDX_W-1:0] tone;
        logic              accept;
        logic              load;
        logic              mul_lo;
        logic              mul_hi;
        logic              upd;
        logic              mul_start;
        t_mop              mul_op;
        logic              track;
        logic              chk1;
        logic              chk2;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic is_end;
        logic mul_done;
        logic out_free;
    } t_sts;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [TONE_W-1:0] lo,
                                                    input logic [TONE_W-1:0] hi);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (lo < REJECTED && hi < REJECTED) begin
            d = DIGIT_MAP[{lo[GIDX_W-1:0], hi[GIDX_W-1:0]}];
        end
        return d;
    endfunction

endpackage

FILE: rtl/dtmf_gd_if.sv
interface dtmf_gd_in_if import dtmf_gd_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;

    modport source(output valid, sample, block_end, input ready);
    modport sink(input valid, sample, block_end, output ready);
endinterface

interface dtmf_gd_out_if import dtmf_gd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic [TONE_W-1:0]  low_tone;
    logic [TONE_W-1:0]  high_tone;

    modport source(output valid, digit, low_tone, high_tone, input ready);
    modport sink(input valid, digit, low_tone, high_tone, output ready);
endinterface

FILE: rtl/dtmf_gd_cfg.sv
module dtmf_gd_cfg import dtmf_gd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    input  logic [TIDX_W-1:0]        i_tone,
    output logic signed [COEF_W-1:0] o_coef
);

    logic signed [COEF_W-1:0] r_mem [NUM_TONES];
    logic [APB_DW-1:0]        r_prdata;
    logic signed [COEF_W-1:0] r_coef;
    logic [TIDX_W-1:0]        w_idx;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign prdata = r_prdata;
    assign o_coef = r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                r_mem[i] <= '0;
            end
        end else if (psel && penable && pwrite) begin
            r_mem[w_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // read data is captured in the setup phase of the transaction
    always_ff @(posedge i_clk) begin
        if (psel && !penable) begin
            r_prdata <= APB_DW'(r_mem[w_idx]);
        end
        r_coef <= r_mem[i_tone];
    end

endmodule

FILE: rtl/dtmf_gd_mul.sv
module dtmf_gd_mul import dtmf_gd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [MUL_W-1:0] i_a,
    input  logic signed [MULB_W-1:0] i_b,
    output logic                    o_done,
    output logic signed [MUL_W-1:0] o_prod
);

    localparam int CW = $clog2(MULB_W);

    logic signed [MUL_W-1:0] r_a;
    logic [MULB_W-1:0]       r_b;
    logic signed [MUL_W-1:0] r_acc;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic                    w_last;

    assign w_last = (r_cnt == CW'(MULB_W - 1));
    assign o_done = r_done;
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // signed shift-add, top multiplier bit has negative weight
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= w_last ? r_acc - r_a : r_acc + r_a;
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_done |-> $past(r_busy);
    endproperty
    assert property (p_done_after_busy) else $error("product done without a run");

    property p_no_restart;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_start;
    endproperty
    assert property (p_no_restart) else $error("multiplier restarted while busy");

    property p_busy_after_start;
        @(posedge i_clk) disable iff (!i_rst_n) i_start |=> r_busy;
    endproperty
    assert property (p_busy_after_start) else $error("multiplier did not start");

endmodule

FILE: rtl/dtmf_gd_dp.sv
module dtmf_gd_dp import dtmf_gd_pkg::*; #(
    parameter int MAX_BLOCK      = MAX_BLOCK_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_block_end,
    input  logic signed [COEF_W-1:0]   i_coef,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [DIGIT_W-1:0]         o_digit,
    output logic [TONE_W-1:0]          o_low_tone,
    output logic [TONE_W-1:0]          o_high_tone
);

    localparam int PROD_W = COEF_W + Q_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam logic signed [SUM_W-1:0] Q_HI = {{(SUM_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] Q_LO = {{(SUM_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};

    logic signed [Q_W-1:0]         r_d1 [NUM_TONES];
    logic signed [Q_W-1:0]         r_d2 [NUM_TONES];
    logic [CNT_W-1:0]              r_cnt;
    logic signed [SAMPLE_W-1:0]    r_x;
    logic                          r_end;
    logic signed [Q_W-1:0]         r_q1;
    logic signed [Q_W-1:0]         r_q2;
    logic signed [COEF_W+HALF_W:0] r_plo;
    logic signed [COEF_W+HALF_W-1:0] r_phi;
    logic signed [P_W-1:0]         r_sum;
    logic signed [X_W-1:0]         r_cross;
    logic signed [P_W-1:0]         r_power;
    logic signed [P_W-1:0]         r_best;
    logic signed [P_W-1:0]         r_second;
    logic                          r_has_second;
    logic [GIDX_W-1:0]             r_bidx;
    logic                          r_floor_fail;
    logic signed [P_W-1:0]         r_scaled;
    logic [2*CNT_W-1:0]            r_nn;
    logic [TONE_W-1:0]             r_lo;
    logic [TONE_W-1:0]             r_hi;
    logic                          r_out_valid;
    logic [DIGIT_W-1:0]            r_digit;
    logic [TONE_W-1:0]             r_low_out;
    logic [TONE_W-1:0]             r_high_out;

    logic signed [PROD_W-1:0]      w_full;
    logic signed [PROD_W-1:0]      w_shift;
    logic signed [SUM_W-1:0]       w_q0w;
    logic signed [Q_W-1:0]         w_q0;
    logic signed [MUL_W-1:0]       w_mul_a;
    logic signed [MULB_W-1:0]      w_mul_b;
    logic                          w_mul_done;
    logic signed [MUL_W-1:0]       w_prod;
    logic signed [MUL_W-1:0]       w_pfull;
    logic [GIDX_W-1:0]             w_gidx;
    logic                          w_fail;

    dtmf_gd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_comb begin
        case (i_cmd.mul_op)
            MOP_SQ1: begin
                w_mul_a = MUL_W'(r_q1);
                w_mul_b = MULB_W'(r_q1);
            end
            MOP_SQ2: begin
                w_mul_a = MUL_W'(r_q2);
                w_mul_b = MULB_W'(r_q2);
            end
            MOP_X12: begin
                w_mul_a = MUL_W'(r_q1);
                w_mul_b = MULB_W'(r_q2);
            end
            MOP_XC: begin
                w_mul_a = MUL_W'(r_cross);
                w_mul_b = MULB_W'(i_coef);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_full  = (PROD_W'(r_phi) <<< HALF_W) + PROD_W'(r_plo);
    assign w_shift = w_full >>> COEF_FRAC_BITS;
    assign w_q0w   = SUM_W'(w_shift) - SUM_W'(r_q2) + SUM_W'(r_x);

    always_comb begin
        if (w_q0w > Q_HI) begin
            w_q0 = Q_HI[Q_W-1:0];
        end else if (w_q0w < Q_LO) begin
            w_q0 = Q_LO[Q_W-1:0];
        end else begin
            w_q0 = w_q0w[Q_W-1:0];
        end
    end

    assign w_pfull = MUL_W'(r_sum) - (w_prod >>> COEF_FRAC_BITS);
    assign w_gidx  = i_cmd.tone[GIDX_W-1:0];
    assign w_fail  = r_floor_fail || (r_best < r_scaled);

    assign o_sts.is_end   = r_end || (r_cnt >= CNT_W'(MAX_BLOCK));
    assign o_sts.mul_done = w_mul_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // filter state and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
            r_cnt <= '0;
        end else if (i_cmd.out_load) begin
            for (int i = 0; i < NUM_TONES; i++) begin
                r_d1[i] <= '0;
                r_d2[i] <= '0;
            end
            r_cnt <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.upd) begin
                r_d1[i_cmd.tone] <= w_q0;
                r_d2[i_cmd.tone] <= r_q1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x   <= i_sample;
            r_end <= i_block_end;
        end
        if (i_cmd.load) begin
            r_q1 <= r_d1[i_cmd.tone];
            r_q2 <= r_d2[i_cmd.tone];
        end
        if (i_cmd.mul_lo) begin
            r_plo <= i_coef * $signed({1'b0, r_q1[HALF_W-1:0]});
        end
        if (i_cmd.mul_hi) begin
            r_phi <= i_coef * $signed(r_q1[Q_W-1:HALF_W]);
        end
        if (w_mul_done) begin
            case (i_cmd.mul_op)
                MOP_SQ1: r_sum   <= w_prod[P_W-1:0];
                MOP_SQ2: r_sum   <= r_sum + w_prod[P_W-1:0];
                MOP_X12: r_cross <= w_prod[X_W-1:0];
                MOP_XC:  r_power <= w_pfull[P_W-1:0];
                default: r_sum   <= r_sum;
            endcase
        end
        r_nn <= r_cnt * r_cnt;
    end

    // strongest tone of the group and the strongest of the rest
    always_ff @(posedge i_clk) begin
        if (i_cmd.track) begin
            if (w_gidx == '0) begin
                r_best       <= r_power;
                r_bidx       <= '0;
                r_has_second <= 1'b0;
            end else if (r_power > r_best) begin
                r_second     <= r_best;
                r_has_second <= 1'b1;
                r_best       <= r_power;
                r_bidx       <= w_gidx;
            end else if (!r_has_second || r_power > r_second) begin
                r_second     <= r_power;
                r_has_second <= 1'b1;
            end
        end
        if (i_cmd.chk1) begin
            r_floor_fail <= (r_best <<< 4) < $signed(P_W'(r_nn));
            r_scaled     <= (r_second <<< 8) + (r_second <<< 7) + (r_second <<< 4);
        end
        if (i_cmd.chk2) begin
            if (i_cmd.tone[TIDX_W-1]) begin
                r_hi <= w_fail ? REJECTED : TONE_W'(r_bidx);
            end else begin
                r_lo <= w_fail ? REJECTED : TONE_W'(r_bidx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_digit    <= digit_of(r_lo, r_hi);
            r_low_out  <= r_lo;
            r_high_out <= r_hi;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_low_tone  = r_low_out;
    assign o_high_tone = r_high_out;

    property p_clear_after_result;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.out_load |=> (r_cnt == '0);
    endproperty
    assert property (p_clear_after_result) else $error("block count not cleared");

    property p_load_when_free;
        @(posedge i_clk) disable iff (!i_rst_n) i_cmd.out_load |-> o_sts.out_free;
    endproperty
    assert property (p_load_when_free) else $error("result overwritten");

    property p_count_bound;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt <= CNT_W'(MAX_BLOCK);
    endproperty
    assert property (p_count_bound) else $error("block count overran");

endmodule

FILE: rtl/dtmf_gd_ctrl.sv
module dtmf_gd_ctrl import dtmf_gd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LOAD  = 14'b00000000000010,
        S_MLO   = 14'b00000000000100,
        S_MHI   = 14'b00000000001000,
        S_UPD   = 14'b00000000010000,
        S_PLOAD = 14'b00000000100000,
        S_PSQ1  = 14'b00000001000000,
        S_PSQ2  = 14'b00000010000000,
        S_PX12  = 14'b00000100000000,
        S_PXC   = 14'b00001000000000,
        S_PACC  = 14'b00010000000000,
        S_G1    = 14'b00100000000000,
        S_G2    = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    localparam logic [TIDX_W-1:0] LAST_TONE = TIDX_W'(NUM_TONES - 1);
    localparam logic [GIDX_W-1:0] LAST_GIDX = GIDX_W'(TONES_PER_GROUP - 1);

    t_state            r_state, n_state;
    logic [TIDX_W-1:0] r_tone, n_tone;
    logic              r_issued, n_issued;

    always_comb begin
        n_state         = r_state;
        n_tone          = r_tone;
        n_issued        = r_issued;
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.tone      = r_tone;
        o_cmd.mul_op    = MOP_SQ1;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_tone       = '0;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_MLO;
            end
            S_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_tone    = r_tone + 1'b1;
                if (r_tone != LAST_TONE) begin
                    n_state = S_LOAD;
                end else if (i_sts.is_end) begin
                    n_state = S_PLOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_PLOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_PSQ1;
            end
            S_PSQ1, S_PSQ2, S_PX12, S_PXC: begin
                case (r_state)
                    S_PSQ1:  o_cmd.mul_op = MOP_SQ1;
                    S_PSQ2:  o_cmd.mul_op = MOP_SQ2;
                    S_PX12:  o_cmd.mul_op = MOP_X12;
                    default: o_cmd.mul_op = MOP_XC;
                endcase
                o_cmd.mul_start = !r_issued;
                n_issued        = 1'b1;
                if (i_sts.mul_done) begin
                    n_issued = 1'b0;
                    case (r_state)
                        S_PSQ1:  n_state = S_PSQ2;
                        S_PSQ2:  n_state = S_PX12;
                        S_PX12:  n_state = S_PXC;
                        default: n_state = S_PACC;
                    endcase
                end
            end
            S_PACC: begin
                o_cmd.track = 1'b1;
                if (r_tone[GIDX_W-1:0] == LAST_GIDX) begin
                    n_state = S_G1;
                end else begin
                    n_tone  = r_tone + 1'b1;
                    n_state = S_PLOAD;
                end
            end
            S_G1: begin
                o_cmd.chk1 = 1'b1;
                n_state    = S_G2;
            end
            S_G2: begin
                o_cmd.chk2 = 1'b1;
                if (r_tone == LAST_TONE) begin
                    n_state = S_DONE;
                end else begin
                    n_tone  = r_tone + 1'b1;
                    n_state = S_PLOAD;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tone   <= '0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tone   <= n_tone;
            r_issued <= n_issued;
        end
    end

    property p_busy_after_accept;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.accept |=> !o_in_ready;
    endproperty
    assert property (p_busy_after_accept) else $error("ready right after a transaction");

    property p_mul_only_when_busy;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.mul_start |-> !o_in_ready;
    endproperty
    assert property (p_mul_only_when_busy) else $error("multiply issued while idle");

    property p_single_issue;
        @(posedge i_clk) disable iff (!i_rst_n) o_cmd.mul_start |=> !o_cmd.mul_start;
    endproperty
    assert property (p_single_issue) else $error("multiply issued twice");

endmodule

FILE: rtl/dtmf_goertzel_detector_core.sv
// DTMF detector: eight Goertzel filters, one per tone, on a sample stream.
// Input channel i_in carries one signed 16-bit sample and a block_end flag
// per transaction; output channel o_out carries digit, low_tone, high_tone.
// Coefficients (2cos terms, signed Q2.16) are written over the APB port at
// byte address 4*i; the user must write them only while the block is idle,
// as the block itself does not enforce it. Each sample takes one accept
// step, then four steps per tone (coefficient read, low and high partial
// products of 18x25 and 18x24 bits, update with saturation).
// On the last sample of a block (block_end, or MAX_BLOCK samples) the eight
// powers are formed with a 48-step shift-add multiplier, four products per
// tone, and then the decision is made for each tone group.
// The result sits in an output register; the next sample is accepted while
// it waits. A new result waits only if the previous one is still not taken.
// Reset clears the filter state, the sample count and the coefficients.
module dtmf_goertzel_detector_core import dtmf_gd_pkg::*; #(
    parameter int MAX_BLOCK      = MAX_BLOCK_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtmf_gd_in_if.sink        i_in,
    dtmf_gd_out_if.source     o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd                     w_cmd;
    t_sts                     w_sts;
    logic signed [COEF_W-1:0] w_coef;
    logic                     w_in_ready;

    assign i_in.ready = w_in_ready;

    dtmf_gd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_tone  (w_cmd.tone),
        .o_coef  (w_coef)
    );

    dtmf_gd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dtmf_gd_dp #(
        .MAX_BLOCK      (MAX_BLOCK),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_in.sample),
        .i_block_end (i_in.block_end),
        .i_coef      (w_coef),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_digit     (o_out.digit),
        .o_low_tone  (o_out.low_tone),
        .o_high_tone (o_out.high_tone)
    );

endmodule

FILE: bench/dtmf_gd_checker.sv
module dtmf_gd_checker import dtmf_gd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dtmf_gd_in_if             i_in,
    dtmf_gd_out_if            i_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [TONE_W-1:0]  low_tone;
        logic [TONE_W-1:0]  high_tone;
    } t_decision;

    localparam logic signed [127:0] Q_HI = (128'sd1 <<< (Q_W - 1)) - 128'sd1;
    localparam logic signed [127:0] Q_LO = -(128'sd1 <<< (Q_W - 1));

    logic signed [COEF_W-1:0] coef_reg [NUM_TONES];
    logic signed [Q_W-1:0]    q_prev   [NUM_TONES];
    logic signed [Q_W-1:0]    q_prev2  [NUM_TONES];
    logic [CNT_W-1:0]         block_count;
    t_decision                decision_queue [$];

    function automatic logic signed [127:0] tone_power(int t);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        a = q_prev[t];
        b = q_prev2[t];
        c = coef_reg[t];
        return a * a + b * b - ((a * b * c) >>> COEF_FRAC_DEF);
    endfunction

    function automatic logic [TONE_W-1:0] pick_tone(int base, logic signed [127:0] nsq);
        logic signed [127:0] p [TONES_PER_GROUP];
        int best;
        best = 0;
        for (int i = 0; i < TONES_PER_GROUP; i++) begin
            p[i] = tone_power(base + i);
            if (p[best] < p[i]) begin
                best = i;
            end
        end
        if (p[best] * 16 < nsq) begin
            return REJECTED;
        end
        for (int i = 0; i < TONES_PER_GROUP; i++) begin
            if (i != best && p[best] < p[i] * 400) begin
                return REJECTED;
            end
        end
        return TONE_W'(best);
    endfunction

    task automatic goertzel_step(logic signed [SAMPLE_W-1:0] x, logic last);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] q0;
        logic signed [127:0] nsq;
        t_decision d;
        for (int t = 0; t < NUM_TONES; t++) begin
            a = q_prev[t];
            b = q_prev2[t];
            c = coef_reg[t];
            q0 = ((c * a) >>> COEF_FRAC_DEF) - b + x;
            if (q0 > Q_HI) q0 = Q_HI;
            if (q0 < Q_LO) q0 = Q_LO;
            q_prev2[t] = q_prev[t];
            q_prev[t] = q0[Q_W-1:0];
        end
        block_count = block_count + 1'b1;
        if (block_count >= MAX_BLOCK_DEF) last = 1'b1;
        if (last) begin
            a = block_count;
            nsq = a * a;
            d.low_tone = pick_tone(0, nsq);
            d.high_tone = pick_tone(TONES_PER_GROUP, nsq);
            d.digit = NO_DIGIT;
            if (d.low_tone < REJECTED && d.high_tone < REJECTED) begin
                d.digit = DIGIT_MAP[{d.low_tone[GIDX_W-1:0], d.high_tone[GIDX_W-1:0]}];
            end
            decision_queue.push_back(d);
            for (int t = 0; t < NUM_TONES; t++) begin
                q_prev[t] = '0;
                q_prev2[t] = '0;
            end
            block_count = '0;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_decision exp_d;
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TONES; t++) begin
                coef_reg[t] = '0;
                q_prev[t] = '0;
                q_prev2[t] = '0;
            end
            block_count = '0;
            decision_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                coef_reg[paddr[APB_AW-1:2]] = pwdata[COEF_W-1:0];
            end
            if (i_in.valid && i_in.ready) begin
                goertzel_step(i_in.sample, i_in.block_end);
            end
            if (i_out.valid && i_out.ready) begin
                if (decision_queue.size() == 0) begin
                    $error("unexpected transaction: digit %0d", i_out.digit);
                    o_fail_count++;
                end else begin
                    exp_d = decision_queue.pop_front();
                    if (i_out.digit !== exp_d.digit) begin
                        $error("digit: expected %0d actual %0d", exp_d.digit, i_out.digit);
                        o_fail_count++;
                    end
                    if (i_out.low_tone !== exp_d.low_tone) begin
                        $error("low_tone: expected %0d actual %0d",
                               exp_d.low_tone, i_out.low_tone);
                        o_fail_count++;
                    end
                    if (i_out.high_tone !== exp_d.high_tone) begin
                        $error("high_tone: expected %0d actual %0d",
                               exp_d.high_tone, i_out.high_tone);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = decision_queue.size();
    end

endmodule

FILE: bench/dtmf_goertzel_detector_core_tb.sv
module dtmf_goertzel_detector_core_tb import dtmf_gd_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam real TWO_PI = 6.283185307179586;
    localparam int  STALL_LIMIT = 50000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                stall_cycles;
    int                phase_items;
    bit                idle_on;
    bit                hold_req;
    real               tone_freq [NUM_TONES] = '{697.0, 770.0, 852.0, 941.0,
                                                1209.0, 1336.0, 1477.0, 1633.0};

    dtmf_gd_in_if  in_ch ();
    dtmf_gd_out_if out_ch ();

    dtmf_goertzel_detector_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dtmf_gd_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // receiver side
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (8000) @(negedge i_clk);
                hold_req = 1'b0;
                out_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic last);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.sample <= s;
        in_ch.block_end <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        phase_items++;
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_results();
        stop_input();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic coef_write(int idx, logic [APB_DW-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx * 4);
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // 0 tuned, 1 top, 2 bottom, 3 random with junk upper bits
    task automatic load_coefs(int setting);
        logic [APB_DW-1:0] v;
        for (int t = 0; t < NUM_TONES; t++) begin
            case (setting)
                0: v = APB_DW'($rtoi(2.0 * $cos(TWO_PI * tone_freq[t] / 8000.0) * 65536.0));
                1: v = 32'h0001_FFFF;
                2: v = 32'hFFFE_0000;
                default: v = $urandom;
            endcase
            coef_write(t, v);
        end
    endtask

    task automatic send_tone_block(int len, int row, int col, int amp_r, int amp_c);
        real wr;
        real wc;
        int s;
        wr = TWO_PI * tone_freq[row] / 8000.0;
        wc = TWO_PI * tone_freq[TONES_PER_GROUP + col] / 8000.0;
        for (int k = 0; k < len; k++) begin
            s = $rtoi(amp_r * $sin(wr * k) + amp_c * $sin(wc * k));
            send_sample(SAMPLE_W'(s), k == len - 1);
        end
    endtask

    task automatic send_noise_block(int len);
        logic [SAMPLE_W-1:0] s;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0: s = 16'h7FFF;
                1: s = 16'h8000;
                default: s = SAMPLE_W'($urandom);
            endcase
            send_sample(s, k == len - 1);
        end
    endtask

    task automatic random_block();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            send_tone_block($urandom_range(24, 80), $urandom_range(0, 3), $urandom_range(0, 3),
                            (kind == 5) ? 0 : $urandom_range(2000, 16000),
                            $urandom_range(0, 16000));
        end else begin
            send_noise_block($urandom_range(1, 12));
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.sample = '0;
        in_ch.block_end = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        stall_cycles = 0;
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset coefficients: extremes and bit patterns
        send_sample(16'sh7FFF, 1'b1);
        send_sample(-16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b1);
        send_sample(-16'sh0001, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'sh5555, 1'b0);
        send_sample(16'shAAAA, 1'b1);
        wait_results();
        load_coefs(0);
        send_tone_block(16, 1, 1, 12000, 12000);
        send_noise_block(2);

        for (int phase = 0; phase < 6; phase++) begin
            wait_results();
            load_coefs(phase < 4 ? phase : 0);
            if (phase == 5) idle_on = 1'b0;
            phase_items = 0;
            if (phase == 3) begin
                hold_req = 1'b1;
                for (int b = 0; b < 8; b++) send_noise_block($urandom_range(1, 3));
            end
            if (phase == 4) send_tone_block(1030, 3, 1, 9000, 9000);
            while (phase_items < 30) begin
                random_block();
                if (phase == 2 && phase_items < 30) begin
                    stop_input();
                    while (pending != 0) @(negedge i_clk);
                end
            end
        end

        stop_input();
        while (pending != 0) @(negedge i_clk);
        repeat (2000) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/dtmf_gd_pkg.sv
rtl/dtmf_gd_if.sv
rtl/dtmf_gd_cfg.sv
rtl/dtmf_gd_mul.sv
rtl/dtmf_gd_dp.sv
rtl/dtmf_gd_ctrl.sv
rtl/dtmf_goertzel_detector_core.sv
bench/dtmf_gd_checker.sv
bench/dtmf_goertzel_detector_core_tb.sv
